// ===== rtl/core/updq_pkg.sv =====
`timescale 1ns / 1ps
// updq_pkg: shared types and constants of the udp port demux with per-port queues
// no dependencies

package updq_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_PAYLOAD_DEF = 1500;
    localparam int TAG_BITS_DEF    = 8;

    localparam logic [7:0]  UDP_PROTO      = 8'd17;
    localparam logic [11:0] ETH_IP_HDR     = 12'd34;
    localparam logic [11:0] ETH_IP_UDP_HDR = 12'd42;
    localparam logic [15:0] UDP_HDR        = 16'd8;

    localparam int IN_DATA_BITS   = 128;
    localparam int IN_USER_BITS   = 2;
    localparam int OUT_DATA_BITS  = 72;
    localparam int OUT_USER_BITS  = 3;
    localparam int RX_LEN_BITS    = 11;
    localparam int COUNT_BITS     = 5;
    localparam int FIELD_TAG_BITS = 8;

    typedef enum logic [1:0] {
        FUNC_BIND    = 2'd0,
        FUNC_DELIVER = 2'd1,
        FUNC_RECEIVE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_TABLE_FULL  = 3'd1,
        STAT_NOT_BOUND   = 3'd2,
        STAT_BAD_FRAME   = 3'd3,
        STAT_BAD_LEN     = 3'd4,
        STAT_QUEUE_FULL  = 3'd5,
        STAT_QUEUE_EMPTY = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic wr;
        logic fresh;
    } t_slot_cmd;

    typedef struct packed {
        logic hit;
        logic free_found;
    } t_slot_flags;

endpackage

// ===== rtl/core/updq_slot_table.sv =====
`timescale 1ns / 1ps
// updq_slot_table: bound port table with per-slot queue head and fill
// depends on updq_pkg

module updq_slot_table
    import updq_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_port,
    input  t_slot_cmd     i_cmd,
    input  logic [SW-1:0] i_slot,
    input  logic [HW-1:0] i_head,
    input  logic [FW-1:0] i_fill,
    output t_slot_flags   o_flags,
    output logic [SW-1:0] o_hit_slot,
    output logic [SW-1:0] o_free_slot,
    output logic [HW-1:0] o_head,
    output logic [FW-1:0] o_fill
);

    logic [NUM_SLOTS-1:0] r_bound;
    logic [15:0]          r_port [NUM_SLOTS];
    logic [HW-1:0]        r_head [NUM_SLOTS];
    logic [FW-1:0]        r_fill [NUM_SLOTS];

    // lowest matching slot and lowest free slot
    always_comb begin
        o_flags     = '0;
        o_hit_slot  = '0;
        o_free_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_bound[i] && (r_port[i] == i_port)) begin
                o_flags.hit = 1'b1;
                o_hit_slot  = SW'(i);
            end
            if (!r_bound[i]) begin
                o_flags.free_found = 1'b1;
                o_free_slot        = SW'(i);
            end
        end
    end

    assign o_head = r_head[o_hit_slot];
    assign o_fill = r_fill[o_hit_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_cmd.wr) begin
            if (i_cmd.fresh) begin
                r_bound[i_slot] <= 1'b1;
            end
            r_head[i_slot] <= i_head;
            r_fill[i_slot] <= i_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_cmd.fresh) begin
            r_port[i_slot] <= i_port;
        end
    end

endmodule

// ===== rtl/core/udp_port_demux_queues.sv =====
`timescale 1ns / 1ps
// udp_port_demux_queues: top level, udp port demux with per-port descriptor queues
// depends on updq_pkg and updq_slot_table

// In the cycle an item is accepted (S_IDLE) the port is matched
// against all slots in parallel, the slot's queue head and fill are updated and
// the descriptor memory is written (deliver) or read (receive); then, in S_RESP,
// the registered memory read is taken into the output register once that register
// is free. No new item is accepted until the result of the last one is loaded. The
// result waits in an output register, so the next item can be accepted while it
// stalls. There is no clearing pass: descriptors are read only after they were
// written.

module udp_port_demux_queues
    import updq_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // port_number, frame_len, ip_protocol, udp_length, source_ip, source_port,
    // buffer_tag, max_len, zero pad
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // func
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_source_ip, out_source_port, rx_len, out_buffer_tag, queue_count
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // status
    output logic [OUT_USER_BITS-1:0] m_axis_tuser
);

    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = NUM_SLOTS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(MAX_PAYLOAD + 1);
    localparam int MW    = 16 + LW + TAG_BITS;

    // input fields
    logic [15:0] in_port;
    logic [11:0] in_frame_len;
    logic [7:0]  in_proto;
    logic [15:0] in_ulen;
    logic [31:0] in_sip;
    logic [15:0] in_sport;
    logic [7:0]  in_tag;
    logic [15:0] in_maxlen;
    t_func       in_func;

    assign in_port      = s_axis_tdata[15:0];
    assign in_frame_len = s_axis_tdata[27:16];
    assign in_proto     = s_axis_tdata[35:28];
    assign in_ulen      = s_axis_tdata[51:36];
    assign in_sip       = s_axis_tdata[83:52];
    assign in_sport     = s_axis_tdata[99:84];
    assign in_tag       = s_axis_tdata[107:100];
    assign in_maxlen    = s_axis_tdata[123:108];
    assign in_func      = t_func'(s_axis_tuser);

    t_state r_state, n_state;
    logic   accept;
    logic   load;

    t_slot_cmd     upd_cmd;
    logic [SW-1:0] upd_slot;
    logic [HW-1:0] upd_head;
    logic [FW-1:0] upd_fill;
    t_slot_flags   look_flags;
    logic [SW-1:0] hit_slot;
    logic [SW-1:0] free_slot;
    logic [HW-1:0] look_head;
    logic [FW-1:0] look_fill;

    updq_slot_table #(
        .NUM_SLOTS   (NUM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_slot_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_port      (in_port),
        .i_cmd       (upd_cmd),
        .i_slot      (upd_slot),
        .i_head      (upd_head),
        .i_fill      (upd_fill),
        .o_flags     (look_flags),
        .o_hit_slot  (hit_slot),
        .o_free_slot (free_slot),
        .o_head      (look_head),
        .o_fill      (look_fill)
    );

    // frame checks
    logic        bad_frame;
    logic        bad_len;
    logic [15:0] plen_full;
    logic [LW-1:0] plen;

    assign plen_full = in_ulen - UDP_HDR;
    assign plen      = plen_full[LW-1:0];
    assign bad_frame = (in_frame_len < ETH_IP_HDR) || (in_proto != UDP_PROTO) ||
                       (in_frame_len < ETH_IP_UDP_HDR);
    assign bad_len   = (in_ulen < UDP_HDR) || (plen_full > 16'(MAX_PAYLOAD));

    // queue positions
    logic [FW:0]   pos_sum;
    logic [FW:0]   pos_wrap;
    logic [HW-1:0] pos_tail;
    logic [HW:0]   head_inc;
    logic [HW-1:0] head_next;
    logic          q_full;
    logic          q_empty;

    assign pos_sum   = (FW+1)'(look_head) + (FW+1)'(look_fill);
    assign pos_wrap  = (pos_sum >= (FW+1)'(QUEUE_DEPTH)) ? pos_sum - (FW+1)'(QUEUE_DEPTH)
                                                         : pos_sum;
    assign pos_tail  = pos_wrap[HW-1:0];
    assign head_inc  = (HW+1)'(look_head) + (HW+1)'(1);
    assign head_next = (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[HW-1:0];
    assign q_full    = (look_fill >= FW'(QUEUE_DEPTH));
    assign q_empty   = (look_fill == '0);

    // descriptor memory access
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [HW-1:0] mem_pos;
    logic [TAG_BITS+7:0] tag_ext;
    logic [MW-1:0] wr_meta;

    assign mem_pos  = (in_func == FUNC_DELIVER) ? pos_tail : look_head;
    assign mem_addr = AW'(hit_slot) * AW'(QUEUE_DEPTH) + AW'(mem_pos);
    assign tag_ext  = {{TAG_BITS{1'b0}}, in_tag};
    assign wr_meta  = {in_sport, plen, tag_ext[TAG_BITS-1:0]};

    t_status       n_status;
    logic [FW-1:0] n_count;
    logic          n_rx_ok;

    always_comb begin
        upd_cmd  = '0;
        upd_slot = hit_slot;
        upd_head = look_head;
        upd_fill = look_fill;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        n_status = STAT_OK;
        n_count  = '0;
        n_rx_ok  = 1'b0;
        unique case (in_func)
            FUNC_BIND: begin
                if (look_flags.hit) begin
                    n_count = look_fill;
                end else if (look_flags.free_found) begin
                    upd_cmd.wr    = accept;
                    upd_cmd.fresh = 1'b1;
                    upd_slot      = free_slot;
                    upd_head      = '0;
                    upd_fill      = '0;
                end else begin
                    n_status = STAT_TABLE_FULL;
                end
            end
            FUNC_DELIVER: begin
                if (bad_frame) begin
                    n_status = STAT_BAD_FRAME;
                end else if (bad_len) begin
                    n_status = STAT_BAD_LEN;
                end else if (!look_flags.hit) begin
                    n_status = STAT_NOT_BOUND;
                end else if (q_full) begin
                    n_status = STAT_QUEUE_FULL;
                    n_count  = look_fill;
                end else begin
                    upd_cmd.wr = accept;
                    upd_fill   = look_fill + FW'(1);
                    mem_we     = accept;
                    n_count    = upd_fill;
                end
            end
            FUNC_RECEIVE: begin
                if (!look_flags.hit) begin
                    n_status = STAT_NOT_BOUND;
                end else if (q_empty) begin
                    n_status = STAT_QUEUE_EMPTY;
                end else begin
                    upd_cmd.wr = accept;
                    upd_head   = head_next;
                    upd_fill   = look_fill - FW'(1);
                    mem_re     = accept;
                    n_rx_ok    = 1'b1;
                    n_count    = upd_fill;
                end
            end
            default: begin
            end
        endcase
    end

    logic [31:0]   r_desc_ip   [DEPTH];
    logic [MW-1:0] r_desc_meta [DEPTH];
    logic [31:0]   r_rd_ip;
    logic [MW-1:0] r_rd_meta;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_desc_ip[mem_addr]   <= in_sip;
            r_desc_meta[mem_addr] <= wr_meta;
        end
        if (mem_re) begin
            r_rd_ip   <= r_desc_ip[mem_addr];
            r_rd_meta <= r_desc_meta[mem_addr];
        end
    end

    // per-item result held until the response cycle
    t_status       r_status;
    logic [FW-1:0] r_count;
    logic          r_rx_ok;
    logic [15:0]   r_maxlen;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_count  <= n_count;
            r_rx_ok  <= n_rx_ok;
            r_maxlen <= in_maxlen;
        end
    end

    // response forming
    logic [15:0]         rd_sport;
    logic [LW-1:0]       rd_plen;
    logic [TAG_BITS-1:0] rd_tag;
    logic [15:0]         rd_plen16;
    logic [15:0]         copy_full;
    logic [TAG_BITS+7:0] rd_tag_ext;
    logic [FW+4:0]       count_ext;
    logic [OUT_DATA_BITS-1:0] n_out_data;

    assign rd_sport   = r_rd_meta[MW-1 -: 16];
    assign rd_plen    = r_rd_meta[TAG_BITS +: LW];
    assign rd_tag     = r_rd_meta[TAG_BITS-1:0];
    assign rd_plen16  = 16'(rd_plen);
    assign copy_full  = (rd_plen16 < r_maxlen) ? rd_plen16 : r_maxlen;
    assign rd_tag_ext = {8'b0, rd_tag};
    assign count_ext  = {5'b0, r_count};

    always_comb begin
        n_out_data          = '0;
        n_out_data[71:67]   = count_ext[COUNT_BITS-1:0];
        if (r_rx_ok) begin
            n_out_data[31:0]  = r_rd_ip;
            n_out_data[47:32] = rd_sport;
            n_out_data[58:48] = copy_full[RX_LEN_BITS-1:0];
            n_out_data[66:59] = rd_tag_ext[FIELD_TAG_BITS-1:0];
        end
    end

    // control
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        load          = (r_state == S_RESP) && (!m_axis_tvalid || m_axis_tready);
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic [OUT_USER_BITS-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= n_out_data;
            r_out_user <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== rtl/core/updq_checker.sv =====
`timescale 1ns / 1ps
// updq_checker: port-level checks of udp_port_demux_queues, bound to the top level
// depends on updq_pkg and udp_port_demux_queues

module updq_checker
    import updq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [OUT_USER_BITS-1:0] m_axis_tuser
);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("ready high right after an accepted item");

    // result appears once the output register is free
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
        else $error("no result after accepted item");

    // failed results carry no descriptor
    a_fail_no_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tdata[66:0] == '0))
        else $error("descriptor fields set on failed item");

    // empty queue reports zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_QUEUE_EMPTY)) |-> (m_axis_tdata[71:67] == '0))
        else $error("queue empty with nonzero count");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind udp_port_demux_queues updq_checker u_updq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for udp_port_demux_queues, directed then random items
// depends on updq_pkg and the udp_port_demux_queues rtl

module testbench;
    import updq_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] port;
        logic [11:0] frame_len;
        logic [7:0]  proto;
        logic [15:0] udp_len;
        logic [31:0] src_ip;
        logic [15:0] udp_sport;
        logic [7:0]  tag;
        logic [15:0] max_len;
    } t_request;

    typedef struct {
        t_status     status;
        logic [31:0] src_ip;
        logic [15:0] udp_sport;
        logic [10:0] rx_len;
        logic [7:0]  tag;
        logic [4:0]  count;
    } t_reply;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // port_number, frame_len, ip_protocol, udp_length, source_ip, source_port,
    // buffer_tag, max_len, zero pad
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    // func
    logic [IN_USER_BITS-1:0]  s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // out_source_ip, out_source_port, rx_len, out_buffer_tag, queue_count
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    // status
    logic [OUT_USER_BITS-1:0] m_axis_tuser;

    // predicted block state
    bit          slot_used [NUM_SLOTS_DEF];
    logic [15:0] slot_port_tbl [NUM_SLOTS_DEF];
    logic [3:0]  fifo_head [NUM_SLOTS_DEF];
    logic [4:0]  fifo_fill [NUM_SLOTS_DEF];
    logic [31:0] desc_ip [NUM_SLOTS_DEF*QUEUE_DEPTH_DEF];
    logic [15:0] desc_sport [NUM_SLOTS_DEF*QUEUE_DEPTH_DEF];
    logic [10:0] desc_plen [NUM_SLOTS_DEF*QUEUE_DEPTH_DEF];
    logic [7:0]  desc_tag [NUM_SLOTS_DEF*QUEUE_DEPTH_DEF];

    t_reply      pending_replies [$];
    logic [15:0] port_pool [POOL_SIZE];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    udp_port_demux_queues DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int lookup_slot(logic [15:0] port);
        int s;
        s = -1;
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            if (s < 0 && slot_used[i] && slot_port_tbl[i] == port) s = i;
        end
        return s;
    endfunction

    function automatic t_reply predict_reply(t_request r);
        t_reply rep;
        int s;
        int idx;
        int plen;
        rep.status = STAT_OK;
        rep.src_ip = '0;
        rep.udp_sport = '0;
        rep.rx_len = '0;
        rep.tag = '0;
        rep.count = '0;
        case (r.func)
            FUNC_BIND: begin
                s = lookup_slot(r.port);
                if (s < 0) begin
                    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                        if (s < 0 && !slot_used[i]) s = i;
                    end
                    if (s >= 0) begin
                        slot_used[s] = 1'b1;
                        slot_port_tbl[s] = r.port;
                        fifo_head[s] = '0;
                        fifo_fill[s] = '0;
                    end
                end
                if (s < 0) rep.status = STAT_TABLE_FULL;
                else rep.count = fifo_fill[s];
            end
            FUNC_DELIVER: begin
                if (r.frame_len < ETH_IP_HDR || r.proto != UDP_PROTO
                        || r.frame_len < ETH_IP_UDP_HDR) begin
                    rep.status = STAT_BAD_FRAME;
                end else if (r.udp_len < UDP_HDR
                        || int'(r.udp_len) - int'(UDP_HDR) > MAX_PAYLOAD_DEF) begin
                    rep.status = STAT_BAD_LEN;
                end else begin
                    s = lookup_slot(r.port);
                    if (s < 0) begin
                        rep.status = STAT_NOT_BOUND;
                    end else if (fifo_fill[s] >= QUEUE_DEPTH_DEF) begin
                        rep.status = STAT_QUEUE_FULL;
                        rep.count = fifo_fill[s];
                    end else begin
                        idx = s * QUEUE_DEPTH_DEF
                            + (int'(fifo_head[s]) + int'(fifo_fill[s])) % QUEUE_DEPTH_DEF;
                        desc_ip[idx] = r.src_ip;
                        desc_sport[idx] = r.udp_sport;
                        desc_plen[idx] = 11'(int'(r.udp_len) - int'(UDP_HDR));
                        desc_tag[idx] = r.tag;
                        fifo_fill[s] = fifo_fill[s] + 5'd1;
                        rep.count = fifo_fill[s];
                    end
                end
            end
            FUNC_RECEIVE: begin
                s = lookup_slot(r.port);
                if (s < 0) begin
                    rep.status = STAT_NOT_BOUND;
                end else if (fifo_fill[s] == 0) begin
                    rep.status = STAT_QUEUE_EMPTY;
                end else begin
                    idx = s * QUEUE_DEPTH_DEF + int'(fifo_head[s]);
                    plen = int'(desc_plen[idx]);
                    rep.src_ip = desc_ip[idx];
                    rep.udp_sport = desc_sport[idx];
                    rep.tag = desc_tag[idx];
                    rep.rx_len = 11'((plen < int'(r.max_len)) ? plen : int'(r.max_len));
                    fifo_head[s] = 4'((int'(fifo_head[s]) + 1) % QUEUE_DEPTH_DEF);
                    fifo_fill[s] = fifo_fill[s] - 5'd1;
                    rep.count = fifo_fill[s];
                end
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(99) < 85) return port_pool[$urandom_range(POOL_SIZE-1)];
        return 16'($urandom_range(65535));
    endfunction

    function automatic t_request random_request();
        t_request r;
        int k;
        k = $urandom_range(99);
        r.func = (k < 10) ? FUNC_BIND : (k < 55) ? FUNC_DELIVER :
                 (k < 95) ? FUNC_RECEIVE : FUNC_UNUSED;
        r.port = pick_port();
        r.src_ip = $urandom();
        r.udp_sport = 16'($urandom_range(65535));
        r.tag = 8'($urandom_range(255));
        r.max_len = ($urandom_range(1)) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(1600));
        if ($urandom_range(99) < 85) begin
            r.frame_len = 12'($urandom_range(4095, 42));
            r.proto = UDP_PROTO;
            r.udp_len = 16'($urandom_range(1508, 8));
        end else begin
            r.frame_len = ($urandom_range(1)) ? 12'($urandom_range(4095))
                                              : 12'($urandom_range(60));
            r.proto = ($urandom_range(1)) ? UDP_PROTO : 8'($urandom_range(255));
            r.udp_len = ($urandom_range(1)) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(1520));
        end
        return r;
    endfunction

    function automatic t_request bind_req(logic [15:0] port);
        t_request r;
        r = random_request();
        r.func = FUNC_BIND;
        r.port = port;
        return r;
    endfunction

    function automatic t_request deliver_req(logic [15:0] port, logic [11:0] flen,
                                             logic [7:0] proto, logic [15:0] ulen);
        t_request r;
        r = random_request();
        r.func = FUNC_DELIVER;
        r.port = port;
        r.frame_len = flen;
        r.proto = proto;
        r.udp_len = ulen;
        return r;
    endfunction

    function automatic t_request receive_req(logic [15:0] port, logic [15:0] max_len);
        t_request r;
        r = random_request();
        r.func = FUNC_RECEIVE;
        r.port = port;
        r.max_len = max_len;
        return r;
    endfunction

    task automatic send_item(t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.func;
        s_axis_tdata <= {4'd0, r.max_len, r.tag, r.udp_sport, r.src_ip, r.udp_len,
                         r.proto, r.frame_len, r.port};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(predict_reply(r));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic test_bind_basics();
        send_item(bind_req(16'h0000));
        send_item(bind_req(16'hFFFF));
        send_item(bind_req(16'h0000));
        send_item(receive_req(16'h0000, 16'hFFFF));
        send_item(receive_req(16'h1234, 16'd100));
    endtask

    task automatic test_frame_checks();
        send_item(deliver_req(16'h0000, 12'd0, 8'd255, 16'd100));
        send_item(deliver_req(16'h0000, 12'd33, UDP_PROTO, 16'd100));
        send_item(deliver_req(16'h0000, 12'd34, UDP_PROTO, 16'd100));
        send_item(deliver_req(16'h0000, 12'd41, UDP_PROTO, 16'd100));
        send_item(deliver_req(16'h0000, 12'd4095, 8'd16, 16'd8));
        send_item(deliver_req(16'h0000, 12'd42, UDP_PROTO, 16'd0));
        send_item(deliver_req(16'h0000, 12'd42, UDP_PROTO, 16'd7));
        send_item(deliver_req(16'h0000, 12'd42, UDP_PROTO, 16'd1509));
        send_item(deliver_req(16'h0000, 12'd42, UDP_PROTO, 16'hFFFF));
        send_item(deliver_req(16'h0000, 12'd42, UDP_PROTO, 16'd8));
        send_item(deliver_req(16'h0000, 12'd4095, UDP_PROTO, 16'd1508));
        send_item(deliver_req(16'h4321, 12'd100, UDP_PROTO, 16'd60));
    endtask

    task automatic test_receive_lengths();
        t_request r;
        send_item(receive_req(16'h0000, 16'hFFFF));
        send_item(receive_req(16'h0000, 16'd0));
        send_item(deliver_req(16'hFFFF, 12'd200, UDP_PROTO, 16'd108));
        send_item(receive_req(16'hFFFF, 16'd50));
        send_item(receive_req(16'hFFFF, 16'd50));
        r = random_request();
        r.func = FUNC_UNUSED;
        r.port = 16'hFFFF;
        r.frame_len = 12'hFFF;
        r.proto = 8'hFF;
        r.udp_len = 16'hFFFF;
        r.src_ip = 32'hFFFF_FFFF;
        r.udp_sport = 16'hFFFF;
        r.tag = 8'hFF;
        r.max_len = 16'hFFFF;
        send_item(r);
    endtask

    task automatic test_queue_overflow(logic [15:0] port);
        for (int i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
            send_item(deliver_req(port, 12'($urandom_range(4095, 42)), UDP_PROTO,
                                  16'($urandom_range(1508, 8))));
        end
        for (int i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
            send_item(receive_req(port, 16'($urandom_range(65535))));
        end
    endtask

    task automatic test_table_full();
        for (int i = 0; i < POOL_SIZE; i++) send_item(bind_req(port_pool[i]));
        send_item(bind_req(16'($urandom_range(65535))));
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) send_item(random_request());
    endtask

    // receiver side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected item, expected none actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                exp = pending_replies.pop_front();
                check_field("status", 32'(exp.status), 32'(m_axis_tuser));
                check_field("source_ip", exp.src_ip, m_axis_tdata[31:0]);
                check_field("source_port", 32'(exp.udp_sport), 32'(m_axis_tdata[47:32]));
                check_field("rx_len", 32'(exp.rx_len), 32'(m_axis_tdata[58:48]));
                check_field("buffer_tag", 32'(exp.tag), 32'(m_axis_tdata[66:59]));
                check_field("queue_count", 32'(exp.count), 32'(m_axis_tdata[71:67]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) port_pool[i] = 16'($urandom_range(65535));
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            slot_used[i] = 1'b0;
            fifo_head[i] = '0;
            fifo_fill[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 68;
        test_bind_basics();
        test_frame_checks();
        test_receive_lengths();
        wait_drained();
        test_queue_overflow(port_pool[0]);
        test_table_full();
        test_random_traffic(250);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 18;
        test_random_traffic(250);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(250);
        test_queue_overflow(port_pool[1]);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (pending_replies.size() != 0) begin
            $display("%0t: %0d items expected but never seen", $time,
                     pending_replies.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/updq_pkg.sv
rtl/core/updq_slot_table.sv
rtl/core/udp_port_demux_queues.sv
rtl/core/updq_checker.sv
bench/testbench.sv
